// ===== sv/rchl_pkg.sv =====
// Shared types and constants for the reset cause history logger.
package rchl_pkg;

   // Ring geometry
   localparam int LOG_DEPTH = 16;
   localparam int SLOT_W    = $clog2(LOG_DEPTH);

   // Reset value of the minimum valid wall time, in seconds
   localparam logic [62:0] MIN_TIME_RESET = 63'd1577836800;

   // Hardware reset cause codes that count as expected
   localparam logic [7:0] CAUSE_POWERON   = 8'd1;
   localparam logic [7:0] CAUSE_EXTERNAL  = 8'd2;
   localparam logic [7:0] CAUSE_SOFTWARE  = 8'd3;
   localparam logic [7:0] CAUSE_DEEPSLEEP = 8'd5;

   typedef enum logic [1:0] {
      KIND_BOOT = 2'd0,
      KIND_MARK = 2'd1,
      KIND_READ = 2'd2,
      KIND_NOP  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [63:0] wall_time;
      logic [31:0]        uptime;
      logic [7:0]         cause_code;
      logic [15:0]        plan_reason;
      logic [15:0]        plan_source;
      logic [31:0]        plan_flags;
      logic [3:0]         read_slot;
   } req_type;

   typedef struct packed {
      logic [31:0] seq_number;
      logic [62:0] boot_time;
      logic        boot_time_ok;
      logic [7:0]  cause_out;
      logic        planned_out;
      logic [15:0] reason_out;
      logic [15:0] source_out;
      logic [31:0] flags_out;
      logic [62:0] request_time;
      logic [31:0] request_uptime;
      logic [31:0] boots_total;
      logic [31:0] unexpected_total;
   } rsp_type;

   // One restart record as kept in the ring
   typedef struct packed {
      logic [31:0] seq;
      logic [62:0] boot_time;
      logic        time_ok;
      logic [7:0]  cause;
      logic        planned;
      logic [15:0] reason;
      logic [15:0] source;
      logic [31:0] flags;
      logic [62:0] req_time;
      logic [31:0] req_uptime;
   } rec_type;

endpackage

// ===== sv/rchl_ring.sv =====
// Ring of restart records with per-entry valid bits; invalid entries read as zero.
module rchl_ring
   import rchl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  rec_type           wr_rec,
   input  logic [SLOT_W-1:0] rd_slot,
   output rec_type           rd_rec
);

   logic [LOG_DEPTH-1:0] vld_ff;
   rec_type              rec_ff [LOG_DEPTH];

   // Valid bits: cleared at reset, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_slot] <= 1'b1;
      end
   end

   // Record storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_ff[wr_slot] <= wr_rec;
      end
   end

   assign rd_rec = vld_ff[rd_slot] ? rec_ff[rd_slot] : '0;

endmodule

// ===== sv/reset_cause_history_logger.sv =====
// Top level: reset cause history logger with pending planned-restart request.
// A taken transaction goes through the input register and the result register onto rsp_*,
// marked by rsp_valid; the receiver cannot stall, so nothing ever waits.
// Throughput: one transaction per cycle while busy is low; input register, one logic pass, result register.
// busy is high during reset and until the first clock edge after reset is released.
// Reset clears the counters, the pending request and the ring; min_valid_time = 1577836800.
module reset_cause_history_logger
   import rchl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [62:0] csr_wr_data
);

   logic              busy_ff;
   logic              accept;
   logic              item_vld_ff;
   req_type           item_ff;
   logic [62:0]       min_time_ff;

   logic [31:0]       seq_cnt_ff,  seq_cnt_in;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [31:0]       boot_cnt_ff, boot_cnt_in;
   logic [31:0]       unexp_cnt_ff, unexp_cnt_in;

   logic              pend_vld_ff, pend_vld_in;
   logic [62:0]       pend_time_ff, pend_time_in;
   logic [31:0]       pend_uptime_ff, pend_uptime_in;
   logic [31:0]       pend_flags_ff, pend_flags_in;
   logic [15:0]       pend_reason_ff, pend_reason_in;
   logic [15:0]       pend_source_ff, pend_source_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              is_boot, is_mark, is_read;
   logic              time_ok;
   logic [62:0]       wall63;
   logic              cause_unexp;
   logic              slot_present;
   rec_type           boot_rec;
   rec_type           rd_rec;
   rec_type           out_rec;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Busy is a registered copy of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_time_ff <= MIN_TIME_RESET;
      end else if (csr_wr_en) begin
         min_time_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   // Decode and time check
   assign is_boot = item_vld_ff && (item_ff.kind == KIND_BOOT);
   assign is_mark = item_vld_ff && (item_ff.kind == KIND_MARK);
   assign is_read = item_vld_ff && (item_ff.kind == KIND_READ);

   assign time_ok = !item_ff.wall_time[63] && (item_ff.wall_time[62:0] >= min_time_ff);
   assign wall63  = time_ok ? item_ff.wall_time[62:0] : '0;

   always_comb begin
      cause_unexp = !(item_ff.cause_code inside
                      {CAUSE_POWERON, CAUSE_EXTERNAL, CAUSE_SOFTWARE, CAUSE_DEEPSLEEP});
   end

   // New record for a boot transaction
   always_comb begin
      boot_rec            = '0;
      boot_rec.seq        = seq_cnt_ff + 32'd1;
      boot_rec.boot_time  = wall63;
      boot_rec.time_ok    = time_ok;
      boot_rec.cause      = item_ff.cause_code;
      boot_rec.planned    = pend_vld_ff;
      if (pend_vld_ff) begin
         boot_rec.reason     = pend_reason_ff;
         boot_rec.source     = pend_source_ff;
         boot_rec.flags      = pend_flags_ff;
         boot_rec.req_time   = pend_time_ff;
         boot_rec.req_uptime = pend_uptime_ff;
      end
   end

   rchl_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (is_boot),
      .wr_slot (next_slot_ff),
      .wr_rec  (boot_rec),
      .rd_slot (SLOT_W'(item_ff.read_slot)),
      .rd_rec  (rd_rec)
   );

   assign slot_present = (32'(item_ff.read_slot) < 32'(LOG_DEPTH));

   // State update
   always_comb begin
      seq_cnt_in     = seq_cnt_ff;
      next_slot_in   = next_slot_ff;
      boot_cnt_in    = boot_cnt_ff;
      unexp_cnt_in   = unexp_cnt_ff;
      pend_vld_in    = pend_vld_ff;
      pend_time_in   = pend_time_ff;
      pend_uptime_in = pend_uptime_ff;
      pend_flags_in  = pend_flags_ff;
      pend_reason_in = pend_reason_ff;
      pend_source_in = pend_source_ff;
      if (is_boot) begin
         seq_cnt_in   = seq_cnt_ff + 32'd1;
         boot_cnt_in  = boot_cnt_ff + 32'd1;
         if (!pend_vld_ff && cause_unexp) begin
            unexp_cnt_in = unexp_cnt_ff + 32'd1;
         end
         if (next_slot_ff == SLOT_W'(LOG_DEPTH - 1)) begin
            next_slot_in = '0;
         end else begin
            next_slot_in = next_slot_ff + SLOT_W'(1);
         end
         pend_vld_in    = 1'b0;
         pend_time_in   = '0;
         pend_uptime_in = '0;
         pend_flags_in  = '0;
         pend_reason_in = '0;
         pend_source_in = '0;
      end else if (is_mark) begin
         pend_vld_in    = 1'b1;
         pend_time_in   = wall63;
         pend_uptime_in = item_ff.uptime;
         pend_flags_in  = item_ff.plan_flags;
         pend_reason_in = item_ff.plan_reason;
         pend_source_in = item_ff.plan_source;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_cnt_ff     <= '0;
         next_slot_ff   <= '0;
         boot_cnt_ff    <= '0;
         unexp_cnt_ff   <= '0;
         pend_vld_ff    <= 1'b0;
         pend_time_ff   <= '0;
         pend_uptime_ff <= '0;
         pend_flags_ff  <= '0;
         pend_reason_ff <= '0;
         pend_source_ff <= '0;
      end else begin
         seq_cnt_ff     <= seq_cnt_in;
         next_slot_ff   <= next_slot_in;
         boot_cnt_ff    <= boot_cnt_in;
         unexp_cnt_ff   <= unexp_cnt_in;
         pend_vld_ff    <= pend_vld_in;
         pend_time_ff   <= pend_time_in;
         pend_uptime_ff <= pend_uptime_in;
         pend_flags_ff  <= pend_flags_in;
         pend_reason_ff <= pend_reason_in;
         pend_source_ff <= pend_source_in;
      end
   end

   // Result formatting
   always_comb begin
      if (is_boot) begin
         out_rec = boot_rec;
      end else if (slot_present) begin
         out_rec = rd_rec;
      end else begin
         out_rec = '0;
      end
      rsp_valid_in                 = is_boot || is_read;
      rsp_data_in.seq_number       = out_rec.seq;
      rsp_data_in.boot_time        = out_rec.boot_time;
      rsp_data_in.boot_time_ok     = out_rec.time_ok;
      rsp_data_in.cause_out        = out_rec.cause;
      rsp_data_in.planned_out      = out_rec.planned;
      rsp_data_in.reason_out       = out_rec.reason;
      rsp_data_in.source_out       = out_rec.source;
      rsp_data_in.flags_out        = out_rec.flags;
      rsp_data_in.request_time     = out_rec.req_time;
      rsp_data_in.request_uptime   = out_rec.req_uptime;
      rsp_data_in.boots_total      = boot_cnt_in;
      rsp_data_in.unexpected_total = unexp_cnt_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A mark transaction never produces a result
   a_mark_silent: assert property (@(posedge clock) disable iff (reset)
      is_mark |=> !rsp_valid)
      else $error("mark transaction produced a result");

   // Every boot bumps the boot counter by one
   a_boot_count: assert property (@(posedge clock) disable iff (reset)
      is_boot |=> (boot_cnt_ff == $past(boot_cnt_ff) + 32'd1))
      else $error("boot counter did not advance");

   // A boot consumes the pending request
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      is_boot |=> !pend_vld_ff)
      else $error("pending request survived a boot");

   // A result only follows a boot or read in the previous cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(is_boot || is_read))
      else $error("result without a boot or read transaction");

   // An invalid boot time is reported as zero
   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.boot_time_ok) |-> (rsp_data.boot_time == '0))
      else $error("invalid boot time not zeroed");
`endif

endmodule

// ===== sim/rchl_checker.sv =====
// Checker for the reset cause history logger: predicts each record and compares results.
module rchl_checker
   import rchl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [62:0] csr_wr_data,
   output int          error_count,
   output int          results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // Predicted block state
   logic [62:0]       min_time;
   logic [31:0]       seq_ctr;
   logic [31:0]       boot_ctr;
   logic [31:0]       unexp_ctr;
   logic [SLOT_W-1:0] write_slot;
   logic              pend_valid;
   logic [62:0]       pend_time;
   logic [31:0]       pend_uptime;
   logic [31:0]       pend_flags;
   logic [15:0]       pend_reason;
   logic [15:0]       pend_source;
   rec_type           history [LOG_DEPTH];

   rsp_type record_due_q[$];
   int      mismatches = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns ERROR %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   function automatic rsp_type record_view(input rec_type rec);
      rsp_type rsp;
      rsp.seq_number       = rec.seq;
      rsp.boot_time        = rec.boot_time;
      rsp.boot_time_ok     = rec.time_ok;
      rsp.cause_out        = rec.cause;
      rsp.planned_out      = rec.planned;
      rsp.reason_out       = rec.reason;
      rsp.source_out       = rec.source;
      rsp.flags_out        = rec.flags;
      rsp.request_time     = rec.req_time;
      rsp.request_uptime   = rec.req_uptime;
      rsp.boots_total      = boot_ctr;
      rsp.unexpected_total = unexp_ctr;
      return rsp;
   endfunction

   // Apply one accepted transaction to the predicted state, queue its record if any
   task automatic log_restart_event(input req_type item);
      rec_type rec;
      logic    wall_ok;
      wall_ok = !item.wall_time[63] && (item.wall_time[62:0] >= min_time);
      case (item.kind)
         KIND_BOOT: begin
            seq_ctr        = seq_ctr + 32'd1;
            rec            = '0;
            rec.seq        = seq_ctr;
            rec.boot_time  = wall_ok ? item.wall_time[62:0] : '0;
            rec.time_ok    = wall_ok;
            rec.cause      = item.cause_code;
            rec.planned    = pend_valid;
            if (pend_valid) begin
               rec.reason     = pend_reason;
               rec.source     = pend_source;
               rec.flags      = pend_flags;
               rec.req_time   = pend_time;
               rec.req_uptime = pend_uptime;
            end
            history[write_slot] = rec;
            boot_ctr = boot_ctr + 32'd1;
            // unplanned boots with an unusual cause
            if (!pend_valid && !(item.cause_code inside {CAUSE_POWERON, CAUSE_EXTERNAL,
                                                         CAUSE_SOFTWARE, CAUSE_DEEPSLEEP})) begin
               unexp_ctr = unexp_ctr + 32'd1;
            end
            write_slot  = write_slot + SLOT_W'(1);
            pend_valid  = 1'b0;
            pend_time   = '0;
            pend_uptime = '0;
            pend_flags  = '0;
            pend_reason = '0;
            pend_source = '0;
            record_due_q.push_back(record_view(rec));
         end
         KIND_MARK: begin
            pend_valid  = 1'b1;
            pend_time   = wall_ok ? item.wall_time[62:0] : '0;
            pend_uptime = item.uptime;
            pend_flags  = item.plan_flags;
            pend_reason = item.plan_reason;
            pend_source = item.plan_source;
         end
         KIND_READ: begin
            record_due_q.push_back(record_view(history[item.read_slot]));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         min_time    = MIN_TIME_RESET;
         seq_ctr     = '0;
         boot_ctr    = '0;
         unexp_ctr   = '0;
         write_slot  = '0;
         pend_valid  = 1'b0;
         pend_time   = '0;
         pend_uptime = '0;
         pend_flags  = '0;
         pend_reason = '0;
         pend_source = '0;
         for (int i = 0; i < LOG_DEPTH; i++) begin
            history[i] = '0;
         end
         record_due_q.delete();
      end else begin
         // results first: they belong to earlier transactions
         if (rsp_valid === 1'b1) begin
            if (record_due_q.size() == 0) begin
               report_mismatch("result with no transaction waiting for one");
            end else begin
               want = record_due_q.pop_front();
               check_field("seq_number", 64'(rsp_data.seq_number), 64'(want.seq_number));
               check_field("boot_time", 64'(rsp_data.boot_time), 64'(want.boot_time));
               check_field("boot_time_ok", 64'(rsp_data.boot_time_ok),
                           64'(want.boot_time_ok));
               check_field("cause_out", 64'(rsp_data.cause_out), 64'(want.cause_out));
               check_field("planned_out", 64'(rsp_data.planned_out),
                           64'(want.planned_out));
               check_field("reason_out", 64'(rsp_data.reason_out), 64'(want.reason_out));
               check_field("source_out", 64'(rsp_data.source_out), 64'(want.source_out));
               check_field("flags_out", 64'(rsp_data.flags_out), 64'(want.flags_out));
               check_field("request_time", 64'(rsp_data.request_time),
                           64'(want.request_time));
               check_field("request_uptime", 64'(rsp_data.request_uptime),
                           64'(want.request_uptime));
               check_field("boots_total", 64'(rsp_data.boots_total),
                           64'(want.boots_total));
               check_field("unexpected_total", 64'(rsp_data.unexpected_total),
                           64'(want.unexpected_total));
            end
         end
         // transaction sees the threshold from before this edge
         if (start === 1'b1 && busy === 1'b0) begin
            log_restart_event(req_data);
         end
         if (csr_wr_en === 1'b1) begin
            min_time = csr_wr_data;
         end
      end
      error_count  <= mismatches;
      results_owed <= record_due_q.size();
   end

endmodule

// ===== sim/tb_reset_cause_history_logger.sv =====
// Testbench top for the reset cause history logger: stimulus, threshold setup and verdict.
module tb_reset_cause_history_logger;
   import rchl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [62:0] csr_wr_data;
   int          error_count;
   int          results_owed;

   logic [62:0] threshold;
   int          idle_pct;
   int          sent;

   reset_cause_history_logger i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rchl_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type build_item(input kind_type kind, input logic [63:0] wall,
                                          input logic [31:0] uptime, input logic [7:0] cause,
                                          input logic [15:0] reason, input logic [15:0] source,
                                          input logic [31:0] flags, input logic [3:0] slot);
      req_type item;
      item.kind        = kind;
      item.wall_time   = wall;
      item.uptime      = uptime;
      item.cause_code  = cause;
      item.plan_reason = reason;
      item.plan_source = source;
      item.plan_flags  = flags;
      item.read_slot   = slot;
      return item;
   endfunction

   // Wall times cluster around the threshold and the sign boundary
   function automatic logic [63:0] random_wall(input logic [62:0] min_t);
      logic [63:0] wall;
      case ($urandom_range(7))
         0: wall = {$urandom, $urandom};
         1: wall = {1'b0, min_t};
         2: wall = {1'b0, min_t - 63'd1};
         3: wall = {1'b0, min_t + 63'd1};
         4: wall = {1'b1, 31'($urandom), $urandom};
         5: wall = '0;
         6: wall = 64'h7FFF_FFFF_FFFF_FFFF;
         default: wall = {1'b0, 31'($urandom), $urandom};
      endcase
      return wall;
   endfunction

   function automatic req_type random_item(input kind_type kind, input logic [62:0] min_t);
      logic [7:0] cause;
      if ($urandom_range(99) < 40) begin
         case ($urandom_range(3))
            0: cause = CAUSE_POWERON;
            1: cause = CAUSE_EXTERNAL;
            2: cause = CAUSE_SOFTWARE;
            default: cause = CAUSE_DEEPSLEEP;
         endcase
      end else begin
         cause = 8'($urandom);
      end
      return build_item(kind, random_wall(min_t), $urandom, cause, 16'($urandom),
                        16'($urandom), $urandom, 4'($urandom));
   endfunction

   function automatic kind_type random_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 36) return KIND_BOOT;
      if (roll < 62) return KIND_MARK;
      if (roll < 95) return KIND_READ;
      return KIND_NOP;
   endfunction

   // Present one transaction, hold until taken, then maybe idle the sender
   task automatic send_item(input req_type item);
      logic [223:0] junk;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      sent++;
      if ($urandom_range(99) < idle_pct) begin
         junk     = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         start    <= 1'b0;
         req_data <= junk[$bits(req_type)-1:0];
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Drain all results, then give the pipeline time to settle after mark transactions
   task automatic wait_idle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [62:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      threshold = value;
   endtask

   task automatic random_phase(input int count);
      sent = 0;
      while (sent < count) begin
         // in about 30 percent of steps, a planned-restart sequence: mark, then boot
         if ($urandom_range(99) < 30) begin
            send_item(random_item(KIND_MARK, threshold));
            send_item(random_item(KIND_BOOT, threshold));
         end else begin
            send_item(random_item(random_kind(), threshold));
         end
      end
   endtask

   initial begin
      logic [63:0] m;
      int          guard;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      threshold   = MIN_TIME_RESET;
      idle_pct    = 17;
      sent        = 0;
      m           = {1'b0, MIN_TIME_RESET};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty ring, time edges, every cause class, planned and overwritten marks
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd0));
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd15));
      send_item(build_item(KIND_BOOT, 64'h8000_0000_0000_0000, '0, 8'd0, '0, '0, '0, '0));
      send_item(build_item(KIND_BOOT, m, '0, CAUSE_POWERON, '0, '0, '0, '0));
      send_item(build_item(KIND_BOOT, m - 64'd1, '0, CAUSE_EXTERNAL, '0, '0, '0, '0));
      send_item(build_item(KIND_BOOT, 64'h7FFF_FFFF_FFFF_FFFF, '0, CAUSE_SOFTWARE,
                           '0, '0, '0, '0));
      send_item(build_item(KIND_BOOT, '1, '0, CAUSE_DEEPSLEEP, '0, '0, '0, '0));
      send_item(build_item(KIND_BOOT, '0, '0, 8'd4, '0, '0, '0, '0));
      send_item(build_item(KIND_BOOT, m + 64'd1, '0, 8'hFF, '0, '0, '0, '0));
      send_item(build_item(KIND_MARK, 64'h7FFF_FFFF_FFFF_FFFF, '1, '0, '1, '1, '1, '0));
      send_item(build_item(KIND_BOOT, m, '0, 8'hFF, '0, '0, '0, '0));
      send_item(build_item(KIND_MARK, '1, '0, '0, '0, '0, '0, '0));
      send_item(build_item(KIND_MARK, m, 32'd1, '0, 16'h1234, 16'hABCD, 32'h8000_0001, '0));
      send_item(build_item(KIND_BOOT, 64'h8000_0000_0000_0000, '0, 8'd6, '0, '0, '0, '0));
      send_item(build_item(KIND_NOP, '1, '1, '1, '1, '1, '1, '1));
      send_item(build_item(KIND_BOOT, m, '0, CAUSE_POWERON, '0, '0, '0, '0));
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd0));
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd7));
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd8));
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd9));
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd15));
      send_item(build_item(KIND_MARK, m + 64'd5, 32'h5555_AAAA, '0, 16'h00FF, 16'hFF00,
                           32'h0F0F_F0F0, '0));
      send_item(build_item(KIND_NOP, '0, '0, '0, '0, '0, '0, '0));
      send_item(build_item(KIND_BOOT, m, '0, 8'd0, '0, '0, '0, '0));
      send_item(build_item(KIND_READ, '0, '0, '0, '0, '0, '0, 4'd10));

      // Random phases over several thresholds and sender idle rates
      write_threshold('0);
      random_phase(530);
      idle_pct = 59;
      write_threshold('1);
      random_phase(530);
      idle_pct = 0;
      write_threshold({31'($urandom), $urandom});
      random_phase(530);

      // Drain, with a bound
      start <= 1'b0;
      guard = 0;
      @(posedge clock);
      while (results_owed != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (6) @(posedge clock);
      if (results_owed != 0) begin
         $display("ERROR %0d expected results never arrived", results_owed);
      end
      if (error_count == 0 && results_owed == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rchl_pkg.sv
sv/rchl_ring.sv
sv/reset_cause_history_logger.sv
sim/rchl_checker.sv
sim/tb_reset_cause_history_logger.sv
